@@ rtl/core/buddy_block_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the buddy block allocator
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and helpers shared by the buddy block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    localparam int ORDERS_DEF     = 12;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int LIST_DEPTH_DEF = 64;

    localparam int FIELD_W  = 16;
    localparam int SIZE_W   = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'd1;

    localparam logic [15:0] REGION_BASE_RST = 16'd4096;
    localparam logic [16:0] REGION_SIZE_RST = 17'd2048;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOMEM  = 2'd1;
    localparam logic [1:0] ST_BADPTR = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    typedef struct packed {
        logic              func;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] request_alignment;
        logic [FIELD_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result_address;
        logic [1:0]         status;
    } rsp_t;

    function automatic logic [4:0] bit_length17(input logic [SIZE_W-1:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/core/bba_div.sv @@
// ----------------------------------------------------------------------------
// bba_div
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_div #(
    parameter int AW = bba_pkg::ADDR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [AW-1:0]               dividend,
    input  logic [bba_pkg::FIELD_W-1:0] divisor,
    output logic                        done,
    output logic [bba_pkg::FIELD_W-1:0] rem
);

    localparam int FW = bba_pkg::FIELD_W;
    localparam int CNT_W = $clog2(AW + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [AW-1:0]     q_reg;
    logic [FW-1:0]     r_reg;
    logic [FW-1:0]     d_reg;
    logic [FW:0]       r_shift;
    logic [FW-1:0]     r_next;

    always_comb
    begin
        r_shift = {r_reg, q_reg[AW-1]};
        if (r_shift >= {1'b0, d_reg})
        begin
            r_next = FW'(r_shift - {1'b0, d_reg});
        end
        else
        begin
            r_next = FW'(r_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(AW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg <= q_reg << 1;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

@@ rtl/core/buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator with per-order free and allocated lists held in RAM.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the transfer until the result
// strobe, which lands with busy low and must be taken that cycle. Each list
// is kept front-last in RAM, so pop and push are one access. An allocate
// splits down level by level, then runs the serial remainder unit when an
// alignment is given. A free visits each order in turn, scans the allocated
// entries, closes the gap with a read and a write per list entry moved, and
// scans the free entries at each merge level. After reset or a region
// register write the block is busy in S_INIT rebuilding the initial free
// block.
`timescale 1ns / 1ps

module buddy_block_allocator_top #(
    parameter int ORDERS     = bba_pkg::ORDERS_DEF,
    parameter int ADDR_BITS  = bba_pkg::ADDR_BITS_DEF,
    parameter int LIST_DEPTH = bba_pkg::LIST_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bba_pkg::req_t                  req,
    output logic                           done,
    output bba_pkg::rsp_t                  rsp,
    input  logic                           cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = ADDR_BITS;
    localparam int OW = $clog2(ORDERS);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int MW = OW + IW;
    localparam int WB = ((AW > ORDERS) ? AW : ORDERS) + 1;
    localparam int WW = ((AW > bba_pkg::FIELD_W) ? AW : bba_pkg::FIELD_W) + 1;
    localparam int FW = bba_pkg::FIELD_W;
    localparam int SW = bba_pkg::SIZE_W;
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);
    localparam logic [OW-1:0] LAST = OW'(ORDERS - 1);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_A_ORD, S_A_CHK, S_A_POP, S_A_SPLIT, S_A_DIV,
        S_F_START, S_F_ORD, S_F_CMP,
        S_SH_RD, S_SH_WR,
        S_F_PUSH, S_M_CHK, S_M_CMP, S_M_PUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     fcnt_reg [ORDERS];
    logic [CW-1:0]     fcnt_next [ORDERS];
    logic [CW-1:0]     acnt_reg [ORDERS];
    logic [CW-1:0]     acnt_next [ORDERS];
    logic [15:0]       rbase_reg, rbase_next;
    logic [SW-1:0]     rsize_reg, rsize_next;
    logic              done_reg, done_next;
    bba_pkg::rsp_t     rsp_reg, rsp_next;

    logic [SW-1:0]     sum_reg, sum_next;
    logic [FW-1:0]     align_reg, align_next;
    logic [AW-1:0]     faddr_reg, faddr_next;
    logic [OW-1:0]     ord_reg, ord_next;
    logic [OW-1:0]     k_reg, k_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     end_reg, end_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [AW-1:0]     tgt_reg, tgt_next;
    logic              sh_alloc_reg, sh_alloc_next;

    logic              f_we, a_we;
    logic [MW-1:0]     f_waddr, f_raddr, a_waddr, a_raddr;
    logic [AW-1:0]     f_wdata, a_wdata, f_rdata, a_rdata;

    logic              div_start, div_done;
    logic [FW-1:0]     div_rem;

    logic [AW-1:0]     init_base;
    logic [SW-1:0]     init_size;
    logic [OW-1:0]     init_ord;

    bba_ram #(.WIDTH(AW), .DEPTH(2 ** MW)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    bba_ram #(.WIDTH(AW), .DEPTH(2 ** MW)) u_alloc_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bba_div #(.AW(AW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (base_reg),
        .divisor  (align_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        logic [4:0] bl;
        bl        = 5'd0;
        init_base = AW'(rbase_reg);
        init_size = rsize_reg;
        if (init_base == '0 && rsize_reg != '0)
        begin
            init_base = AW'(1);
            init_size = rsize_reg - 1'b1;
        end
        if (init_size != '0)
        begin
            bl = bba_pkg::bit_length17(init_size) - 1'b1;
        end
        if (32'(bl) > ORDERS - 1)
        begin
            init_ord = LAST;
        end
        else
        begin
            init_ord = OW'(bl);
        end
    end

    always_comb
    begin
        logic [4:0]    bl;
        logic          found;
        logic [OW-1:0] j;
        logic [OW-1:0] kk;
        logic          hit;
        logic [WB-1:0] step;
        logic [WW-1:0] addr_w;

        bl     = 5'd0;
        found  = 1'b0;
        j      = '0;
        kk     = k_reg - 1'b1;
        hit    = 1'b0;
        step   = WB'(1) << k_reg;
        addr_w = '0;

        state_next    = state_reg;
        fcnt_next     = fcnt_reg;
        acnt_next     = acnt_reg;
        rbase_next    = rbase_reg;
        rsize_next    = rsize_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        sum_next      = sum_reg;
        align_next    = align_reg;
        faddr_next    = faddr_reg;
        ord_next      = ord_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        base_next     = base_reg;
        tgt_next      = tgt_reg;
        sh_alloc_next = sh_alloc_reg;

        f_we      = 1'b0;
        f_waddr   = '0;
        f_wdata   = '0;
        f_raddr   = {k_reg, idx_reg};
        a_we      = 1'b0;
        a_waddr   = '0;
        a_wdata   = '0;
        a_raddr   = {k_reg, idx_reg};
        div_start = 1'b0;

        if (cfg_we && (cfg_index == bba_pkg::CFG_REGION_BASE ||
                       cfg_index == bba_pkg::CFG_REGION_SIZE))
        begin
            if (cfg_index == bba_pkg::CFG_REGION_BASE)
            begin
                rbase_next = cfg_data[15:0];
            end
            else
            begin
                rsize_next = cfg_data[SW-1:0];
            end
            for (int i = 0; i < ORDERS; i++)
            begin
                fcnt_next[i] = '0;
                acnt_next[i] = '0;
            end
            state_next = S_INIT;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    f_we                = 1'b1;
                    f_waddr             = {init_ord, IW'(0)};
                    f_wdata             = init_base;
                    fcnt_next[init_ord] = CW'(1);
                    state_next          = S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        sum_next   = SW'(req.request_size) + SW'(req.request_alignment);
                        align_next = req.request_alignment;
                        faddr_next = AW'(req.free_address);
                        state_next = (req.func == bba_pkg::FUNC_FREE) ? S_F_START : S_A_ORD;
                    end
                end
                S_A_ORD:
                begin
                    bl = bba_pkg::bit_length17(sum_reg - 1'b1);
                    if (sum_reg == '0 || 32'(bl) >= ORDERS)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_NOMEM};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ord_next   = OW'(bl);
                        state_next = S_A_CHK;
                    end
                end
                S_A_CHK:
                begin
                    for (int i = 0; i < ORDERS; i++)
                    begin
                        if (!found && OW'(i) >= ord_reg && fcnt_reg[i] != '0)
                        begin
                            found = 1'b1;
                            j     = OW'(i);
                        end
                    end
                    if (!found)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_NOMEM};
                        state_next = S_IDLE;
                    end
                    else if (acnt_reg[ord_reg] == FULL)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_OVF};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        f_raddr      = {j, IW'(fcnt_reg[j] - 1'b1)};
                        fcnt_next[j] = fcnt_reg[j] - 1'b1;
                        k_next       = j;
                        state_next   = S_A_POP;
                    end
                end
                S_A_POP:
                begin
                    base_next  = f_rdata;
                    state_next = S_A_SPLIT;
                end
                S_A_SPLIT:
                begin
                    if (k_reg > ord_reg)
                    begin
                        f_we          = 1'b1;
                        f_waddr       = {kk, IW'(fcnt_reg[kk])};
                        f_wdata       = AW'(WB'(base_reg) + (WB'(1) << kk));
                        fcnt_next[kk] = fcnt_reg[kk] + 1'b1;
                        k_next        = kk;
                    end
                    else
                    begin
                        a_we               = 1'b1;
                        a_waddr            = {ord_reg, IW'(acnt_reg[ord_reg])};
                        a_wdata            = base_reg;
                        acnt_next[ord_reg] = acnt_reg[ord_reg] + 1'b1;
                        if (align_reg == '0)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: FW'(base_reg),
                                           status: bba_pkg::ST_OK};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_A_DIV;
                        end
                    end
                end
                S_A_DIV:
                begin
                    if (div_done)
                    begin
                        addr_w     = WW'(base_reg) + WW'(align_reg) - WW'(div_rem);
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: FW'(AW'(addr_w)),
                                       status: bba_pkg::ST_OK};
                        state_next = S_IDLE;
                    end
                end
                S_F_START:
                begin
                    if (faddr_reg == '0)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_OK};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_F_ORD;
                    end
                end
                S_F_ORD:
                begin
                    if (acnt_reg[k_reg] == '0)
                    begin
                        if (k_reg == LAST)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: bba_pkg::ST_BADPTR};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next   = IW'(acnt_reg[k_reg] - 1'b1);
                        a_raddr    = {k_reg, IW'(acnt_reg[k_reg] - 1'b1)};
                        state_next = S_F_CMP;
                    end
                end
                S_F_CMP:
                begin
                    hit = (faddr_reg >= a_rdata) &&
                          (WB'(faddr_reg) < WB'(a_rdata) + step);
                    if (hit)
                    begin
                        base_next = a_rdata;
                        if (fcnt_reg[k_reg] == FULL)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: bba_pkg::ST_OVF};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            end_next      = IW'(acnt_reg[k_reg] - 1'b1);
                            sh_alloc_next = 1'b1;
                            state_next    = S_SH_RD;
                        end
                    end
                    else if (idx_reg == '0)
                    begin
                        if (k_reg == LAST)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: bba_pkg::ST_BADPTR};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = S_F_ORD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        a_raddr  = {k_reg, idx_reg - 1'b1};
                    end
                end
                S_SH_RD:
                begin
                    if (idx_reg == end_reg)
                    begin
                        if (sh_alloc_reg)
                        begin
                            acnt_next[k_reg] = acnt_reg[k_reg] - 1'b1;
                            state_next       = S_F_PUSH;
                        end
                        else
                        begin
                            fcnt_next[k_reg] = fcnt_reg[k_reg] - CW'(2);
                            state_next       = S_M_PUSH;
                        end
                    end
                    else
                    begin
                        a_raddr    = {k_reg, idx_reg + 1'b1};
                        f_raddr    = {k_reg, idx_reg + 1'b1};
                        state_next = S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    if (sh_alloc_reg)
                    begin
                        a_we    = 1'b1;
                        a_waddr = {k_reg, idx_reg};
                        a_wdata = a_rdata;
                    end
                    else
                    begin
                        f_we    = 1'b1;
                        f_waddr = {k_reg, idx_reg};
                        f_wdata = f_rdata;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SH_RD;
                end
                S_F_PUSH:
                begin
                    f_we             = 1'b1;
                    f_waddr          = {k_reg, IW'(fcnt_reg[k_reg])};
                    f_wdata          = base_reg;
                    fcnt_next[k_reg] = fcnt_reg[k_reg] + 1'b1;
                    tgt_next         = base_reg;
                    state_next       = S_M_CHK;
                end
                S_M_CHK:
                begin
                    if (k_reg == LAST || fcnt_reg[k_reg] < CW'(2))
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_OK};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = IW'(fcnt_reg[k_reg] - CW'(2));
                        f_raddr    = {k_reg, IW'(fcnt_reg[k_reg] - CW'(2))};
                        state_next = S_M_CMP;
                    end
                end
                S_M_CMP:
                begin
                    hit = (WB'(f_rdata) + step == WB'(tgt_reg)) ||
                          (WB'(tgt_reg) + step == WB'(f_rdata));
                    if (hit)
                    begin
                        if (fcnt_reg[k_reg + 1'b1] == FULL)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{result_address: '0, status: bba_pkg::ST_OVF};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            tgt_next      = (f_rdata < tgt_reg) ? f_rdata : tgt_reg;
                            end_next      = IW'(fcnt_reg[k_reg] - CW'(2));
                            sh_alloc_next = 1'b0;
                            state_next    = S_SH_RD;
                        end
                    end
                    else if (idx_reg == '0)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{result_address: '0, status: bba_pkg::ST_OK};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        f_raddr  = {k_reg, idx_reg - 1'b1};
                    end
                end
                S_M_PUSH:
                begin
                    f_we                      = 1'b1;
                    f_waddr                   = {k_reg + 1'b1,
                                                 IW'(fcnt_reg[k_reg + 1'b1])};
                    f_wdata                   = tgt_reg;
                    fcnt_next[k_reg + 1'b1]   = fcnt_reg[k_reg + 1'b1] + 1'b1;
                    k_next                    = k_reg + 1'b1;
                    state_next                = S_M_CHK;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            for (int i = 0; i < ORDERS; i++)
            begin
                fcnt_reg[i] <= '0;
                acnt_reg[i] <= '0;
            end
            rbase_reg    <= bba_pkg::REGION_BASE_RST;
            rsize_reg    <= bba_pkg::REGION_SIZE_RST;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            sh_alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fcnt_reg     <= fcnt_next;
            acnt_reg     <= acnt_next;
            rbase_reg    <= rbase_next;
            rsize_reg    <= rsize_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            sh_alloc_reg <= sh_alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        align_reg <= align_next;
        faddr_reg <= faddr_next;
        ord_reg   <= ord_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        base_reg  <= base_next;
        tgt_reg   <= tgt_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ rtl/core/bba_check.sv @@
// ----------------------------------------------------------------------------
// bba_check
// Port-level checks on the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_macros.svh"

module bba_check (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input bba_pkg::rsp_t rsp,
    input logic          cfg_we
);

    `BBA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result while busy")
    `BBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "transfer did not start work")
    `BBA_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_we && !busy, busy, "config did not rebuild")
    `BBA_ASSERT_NOW(a_fail_null, clk, rst_n, done && rsp.status != bba_pkg::ST_OK, rsp.result_address == '0, "failed result carries an address")
    `BBA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than one cycle")

endmodule

bind buddy_block_allocator_top bba_check u_bba_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .rsp    (rsp),
    .cfg_we (cfg_we)
);

@@ tb/tb_buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// Self-checking bench for the buddy allocator: a scoreboard keeps its own
// copy of the free and allocated lists per order, predicts status and address
// for every accepted request, and checks each result strobe in order over
// several region settings, with random request gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top;

    import bba_pkg::*;

    localparam int NORD   = ORDERS_DEF;
    localparam int DEPTH  = LIST_DEPTH_DEF;
    localparam int LIMIT  = 20000000;

    class alloc_scoreboard;
        logic [15:0] free_blk[NORD][DEPTH];
        int          free_cnt[NORD];
        logic [15:0] used_blk[NORD][DEPTH];
        int          used_cnt[NORD];
        logic [15:0] base_reg;
        logic [16:0] size_reg;
        rsp_t        want_q[$];
        int          errors;
        int          checked;
        int          n_ok;
        int          n_nomem;
        int          n_bad;
        int          n_ovf;

        function new();
            base_reg = REGION_BASE_RST;
            size_reg = REGION_SIZE_RST;
            errors   = 0;
            checked  = 0;
            n_ok = 0; n_nomem = 0; n_bad = 0; n_ovf = 0;
            rebuild();
        endfunction

        function int bitlen(int v);
            int n;
            n = 0;
            while (v != 0)
            begin
                n++;
                v = v >> 1;
            end
            return n;
        endfunction

        function void free_push(int o, logic [15:0] v);
            if (free_cnt[o] >= DEPTH)
                return;
            for (int i = free_cnt[o]; i > 0; i--)
                free_blk[o][i] = free_blk[o][i-1];
            free_blk[o][0] = v;
            free_cnt[o]++;
        endfunction

        function void free_drop(int o, int pos);
            for (int i = pos; i < free_cnt[o] - 1; i++)
                free_blk[o][i] = free_blk[o][i+1];
            free_cnt[o]--;
        endfunction

        function void used_push(int o, logic [15:0] v);
            for (int i = used_cnt[o]; i > 0; i--)
                used_blk[o][i] = used_blk[o][i-1];
            used_blk[o][0] = v;
            used_cnt[o]++;
        endfunction

        function void used_drop(int o, int pos);
            for (int i = pos; i < used_cnt[o] - 1; i++)
                used_blk[o][i] = used_blk[o][i+1];
            used_cnt[o]--;
        endfunction

        function void rebuild();
            int b;
            int s;
            int o;
            b = base_reg;
            s = size_reg;
            for (int k = 0; k < NORD; k++)
            begin
                free_cnt[k] = 0;
                used_cnt[k] = 0;
            end
            if (b == 0 && s > 0)
            begin
                b = 1;
                s--;
            end
            o = (s == 0) ? 0 : bitlen(s) - 1;
            if (o > NORD - 1)
                o = NORD - 1;
            free_push(o, 16'(b));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_REGION_BASE)
                base_reg = d[15:0];
            else
                size_reg = d;
            rebuild();
        endfunction

        function rsp_t do_alloc(int sz, int al);
            rsp_t r;
            int   o;
            int   j;
            int   b;
            r = '0;
            if (sz + al == 0)
            begin
                r.status = ST_NOMEM;
                return r;
            end
            o = bitlen(sz + al - 1);
            if (o >= NORD)
            begin
                r.status = ST_NOMEM;
                return r;
            end
            for (j = o; j < NORD; j++)
                if (free_cnt[j] != 0)
                    break;
            if (j >= NORD)
            begin
                r.status = ST_NOMEM;
                return r;
            end
            if (used_cnt[o] >= DEPTH)
            begin
                r.status = ST_OVF;
                return r;
            end
            for (int k = o; k < j; k++)
                if (free_cnt[k] >= DEPTH)
                begin
                    r.status = ST_OVF;
                    return r;
                end
            b = free_blk[j][0];
            free_drop(j, 0);
            for (int k = j; k > o; k--)
                free_push(k - 1, 16'(b + (1 << (k - 1))));
            used_push(o, 16'(b));
            r.result_address = (al != 0) ? 16'(b + al - (b % al)) : 16'(b);
            r.status = ST_OK;
            return r;
        endfunction

        function logic [1:0] do_free(int a);
            int  o;
            int  pos;
            int  k;
            int  m;
            int  t;
            int  lo;
            bit  found;
            bit  hit;
            found = 0;
            o = 0;
            pos = 0;
            if (a == 0)
                return ST_OK;
            for (k = 0; k < NORD && !found; k++)
                for (int i = 0; i < used_cnt[k]; i++)
                    if (a >= used_blk[k][i] && a < int'(used_blk[k][i]) + (1 << k))
                    begin
                        found = 1;
                        o = k;
                        pos = i;
                        break;
                    end
            if (!found)
                return ST_BADPTR;
            if (free_cnt[o] >= DEPTH)
                return ST_OVF;
            free_push(o, used_blk[o][pos]);
            used_drop(o, pos);
            k = o;
            while (k + 1 < NORD)
            begin
                t = free_blk[k][0];
                hit = 0;
                for (m = 1; m < free_cnt[k]; m++)
                    if (t - int'(free_blk[k][m]) == (1 << k)
                        || int'(free_blk[k][m]) - t == (1 << k))
                    begin
                        hit = 1;
                        break;
                    end
                if (!hit)
                    break;
                if (free_cnt[k + 1] >= DEPTH)
                    return ST_OVF;
                lo = (free_blk[k][m] < t) ? free_blk[k][m] : t;
                free_drop(k, m);
                free_drop(k, 0);
                free_push(k + 1, 16'(lo));
                k++;
            end
            return ST_OK;
        endfunction

        function rsp_t note_request(req_t q);
            rsp_t r;
            r = '0;
            if (q.func == FUNC_ALLOC)
                r = do_alloc(q.request_size, q.request_alignment);
            else
                r.status = do_free(q.free_address);
            case (r.status)
                ST_OK:     n_ok++;
                ST_NOMEM:  n_nomem++;
                ST_BADPTR: n_bad++;
                default:   n_ovf++;
            endcase
            want_q.push_back(r);
            return r;
        endfunction

        function void check_result(rsp_t got);
            rsp_t w;
            checked++;
            if (want_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: addr %h status %0d",
                         $time, got.result_address, got.status);
                return;
            end
            w = want_q.pop_front();
            if (got.result_address !== w.result_address)
            begin
                errors++;
                $display("%0t: address expected %h actual %h",
                         $time, w.result_address, got.result_address);
            end
            if (got.status !== w.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alloc_scoreboard sb;
    logic [15:0]     live_addr[$];
    int              cycles;
    int              item_no;

    buddy_block_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && done)
            sb.check_result(rsp);
    end

    task automatic send(req_t q);
        rsp_t r;
        if (!(item_no >= 150 && item_no < 260) && $urandom_range(99) < 37)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = sb.note_request(q);
        if (q.func == FUNC_ALLOC && r.status == ST_OK)
            live_addr.push_back(r.result_address);
        item_no++;
    endtask

    task automatic alloc(int sz, int al);
        req_t q;
        q = '0;
        q.func = FUNC_ALLOC;
        q.request_size = 16'(sz);
        q.request_alignment = 16'(al);
        q.free_address = 16'($urandom);
        send(q);
    endtask

    task automatic release_addr(int a);
        req_t q;
        q = '0;
        q.func = FUNC_FREE;
        q.request_size = 16'($urandom);
        q.request_alignment = 16'($urandom);
        q.free_address = 16'(a);
        send(q);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(d);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, CFG_DATA_W'(d));
        live_addr.delete();
    endtask

    task automatic random_phase(int n, int max_sz);
        int a;
        int pick;
        int al;
        repeat (n)
        begin
            if ($urandom_range(99) < 55 || live_addr.size() == 0)
            begin
                case ($urandom_range(5))
                    0: al = 0;
                    1: al = 1;
                    2: al = 1 << $urandom_range(6);
                    3: al = $urandom_range(1, 40);
                    4: al = 0;
                    default: al = ($urandom_range(9) == 0) ? $urandom_range(65535) : 0;
                endcase
                if ($urandom_range(19) == 0)
                    alloc($urandom_range(65535), al);
                else
                    alloc($urandom_range(max_sz), al);
            end
            else if ($urandom_range(9) < 8)
            begin
                pick = $urandom_range(live_addr.size() - 1);
                a = live_addr[pick];
                live_addr.delete(pick);
                if ($urandom_range(3) == 0)
                    a = a - $urandom_range(1, 3);
                release_addr(a);
                if ($urandom_range(15) == 0)
                    release_addr(a);
            end
            else
                release_addr($urandom_range(65535));
        end
    endtask

    initial
    begin
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_REGION_BASE;
        cfg_data  = '0;
        cycles    = 0;
        item_no   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        alloc(0, 0);
        alloc(65535, 65535);
        alloc(4096, 0);
        alloc(1, 0);
        alloc(1, 1);
        alloc(16, 16);
        alloc(100, 3);
        alloc(2048, 0);
        release_addr(0);
        release_addr(65535);
        release_addr(4096);
        release_addr(4097);
        release_addr(4097);
        release_addr(4096 + 16 + 16);
        alloc(1024, 0);
        alloc(1024, 0);
        alloc(1, 0);
        release_addr(4096);
        release_addr(4096 + 1024);
        release_addr(4096 + 1024);
        alloc(0, 2048);

        random_phase(110, 200);

        write_reg(CFG_REGION_BASE, 0);
        write_reg(CFG_REGION_SIZE, 65536);
        random_phase(120, 3000);

        write_reg(CFG_REGION_BASE, 16'hFFFF);
        write_reg(CFG_REGION_SIZE, 1);
        random_phase(30, 4);

        write_reg(CFG_REGION_SIZE, 0);
        random_phase(20, 2);

        write_reg(CFG_REGION_BASE, 16'h8000);
        write_reg(CFG_REGION_SIZE, 4096);
        repeat (75) alloc($urandom_range(1), 0);
        random_phase(80, 2);

        write_reg(CFG_REGION_BASE, $urandom_range(1, 65535));
        write_reg(CFG_REGION_SIZE, $urandom_range(1, 131071));
        random_phase(100, 600);

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d requests over 6 region settings: %0d ok, %0d out of memory,",
                 item_no, sb.n_ok, sb.n_nomem);
        $display("  %0d bad pointer, %0d overflow; %0d results checked",
                 sb.n_bad, sb.n_ovf, sb.checked);
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
